[hw/rtl/fprm_pkg.sv]
// Shared widths, register indexes and arithmetic helpers of the pixel rotation mapper.
package fprm_pkg;

	localparam int COORD_W = 13;  // source coordinates and centers
	localparam int OFF_W   = 14;  // offset from the figure center
	localparam int OUT_W   = 14;  // destination coordinates
	localparam int COEF_W  = 16;  // sin and cos, Q14
	localparam int TAN_W   = 23;  // tan(a/2), Q14
	localparam int Q_BITS  = 14;
	localparam int A_W     = 24;  // first shear result
	localparam int B_W     = 25;  // second shear result
	localparam int ROT_W   = 34;  // rotated offset, any mode
	localparam int WIDE_W  = ROT_W + 1;
	localparam int RND_W   = 48;  // working width of the Q14 rounding step
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam int IMAGE_WIDTH  = 1024;
	localparam int IMAGE_HEIGHT = 1024;

	localparam logic [RND_W-1:0] Q_HALF = RND_W'(1) << (Q_BITS - 1);
	localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [WIDE_W-1:0] OUT_MIN = -WIDE_W'(1 << (OUT_W - 1));

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_COS      = 3'd1,
		REG_SIN      = 3'd2,
		REG_TAN_HALF = 3'd3,
		REG_SRC_CX   = 3'd4,
		REG_SRC_CY   = 3'd5,
		REG_DST_CX   = 3'd6,
		REG_DST_CY   = 3'd7
	} reg_idx_t;

	localparam logic MODE_DIRECT = 1'b0;
	localparam logic MODE_SHEAR  = 1'b1;

	// What stages 1 to 7 carry besides their arithmetic.
	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic                      filled;
		logic                      mode;
	} pix_info_t;

	// Q14 to integer on the magnitude: half away from zero, or toward zero.
	function automatic logic signed [RND_W-1:0] q_round(input logic signed [RND_W-1:0] v,
	                                                    input logic away);
		logic [RND_W-1:0] mag;
		logic [RND_W-1:0] r;
		mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
		r = (mag + (away ? Q_HALF : '0)) >> Q_BITS;
		return v[RND_W-1] ? -signed'(r) : signed'(r);
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
		if (v > OUT_MAX) begin
			return OUT_MAX[OUT_W-1:0];
		end else if (v < OUT_MIN) begin
			return OUT_MIN[OUT_W-1:0];
		end
		return v[OUT_W-1:0];
	endfunction

	function automatic logic in_image(input logic signed [WIDE_W-1:0] x,
	                                  input logic signed [WIDE_W-1:0] y);
		return (x >= 0) && (x < WIDE_W'(IMAGE_WIDTH)) && (y >= 0) && (y < WIDE_W'(IMAGE_HEIGHT));
	endfunction

endpackage

[hw/rtl/figure_pixel_rotation_mapper.sv]
// Top level of the figure pixel rotation mapper: register port and eight-stage pipeline.
//
// One figure pixel enters on the input channel (in_valid/in_ready with src_x,
// src_y, filled) and one result leaves on the output channel (out_valid/out_ready
// with read_x, read_y, write_x, write_y, write_enable), in order.
// Software sets the mode, Q14 sin, cos and tan(a/2) and the two centers over the
// APB port while no pixel is in flight; a read returns the register bits.
//
// A pixel passes the eight registered stages in order. Throughput is one pixel
// per cycle while out_ready stays high: every stage registers its data with
// a valid bit, and the longest stage holds one multiplier (the shear path chains
// three multiplies, each followed by a rounding stage, which sets the depth).
//
// When the receiver stalls, the last stage holds its result and each stage
// behind it keeps accepting until it meets a full stage, so bubbles are
// squeezed out and in_ready drops only once all eight stages are full.
// Nothing is dropped or repeated.
//
// Reset (arst_n low, asynchronous) empties the pipeline and returns the
// registers to direct mode, cos 1.0, sin 0, tan 0 and zero centers.
module figure_pixel_rotation_mapper (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [fprm_pkg::ADDR_W-1:0]          paddr,
	input  logic [fprm_pkg::DATA_W-1:0]          pwdata,
	output logic [fprm_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	// pixel input
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [fprm_pkg::COORD_W-1:0]  src_x,
	input  logic signed [fprm_pkg::COORD_W-1:0]  src_y,
	input  logic                                 filled,
	// result output
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fprm_pkg::COORD_W-1:0]  read_x,
	output logic signed [fprm_pkg::COORD_W-1:0]  read_y,
	output logic signed [fprm_pkg::OUT_W-1:0]    write_x,
	output logic signed [fprm_pkg::OUT_W-1:0]    write_y,
	output logic                                 write_enable
);

	// ---------------------------------------------------------------- registers
	logic                                 mode_q;
	logic signed [fprm_pkg::COEF_W-1:0]   cos_q;
	logic signed [fprm_pkg::COEF_W-1:0]   sin_q;
	logic signed [fprm_pkg::TAN_W-1:0]    tan_q;
	logic signed [fprm_pkg::COORD_W-1:0]  scx_q;
	logic signed [fprm_pkg::COORD_W-1:0]  scy_q;
	logic signed [fprm_pkg::COORD_W-1:0]  dcx_q;
	logic signed [fprm_pkg::COORD_W-1:0]  dcy_q;

	fprm_pkg::reg_idx_t reg_idx;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = fprm_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fprm_pkg::MODE_DIRECT;
			cos_q  <= fprm_pkg::COEF_W'(1 << fprm_pkg::Q_BITS);
			sin_q  <= '0;
			tan_q  <= '0;
			scx_q  <= '0;
			scy_q  <= '0;
			dcx_q  <= '0;
			dcy_q  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				fprm_pkg::REG_MODE:     mode_q <= pwdata[0];
				fprm_pkg::REG_COS:      cos_q  <= pwdata[fprm_pkg::COEF_W-1:0];
				fprm_pkg::REG_SIN:      sin_q  <= pwdata[fprm_pkg::COEF_W-1:0];
				fprm_pkg::REG_TAN_HALF: tan_q  <= pwdata[fprm_pkg::TAN_W-1:0];
				fprm_pkg::REG_SRC_CX:   scx_q  <= pwdata[fprm_pkg::COORD_W-1:0];
				fprm_pkg::REG_SRC_CY:   scy_q  <= pwdata[fprm_pkg::COORD_W-1:0];
				fprm_pkg::REG_DST_CX:   dcx_q  <= pwdata[fprm_pkg::COORD_W-1:0];
				fprm_pkg::REG_DST_CY:   dcy_q  <= pwdata[fprm_pkg::COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Reads return the raw register bits, zero-extended.
	always_comb begin
		case (reg_idx)
			fprm_pkg::REG_MODE:     prdata = fprm_pkg::DATA_W'(mode_q);
			fprm_pkg::REG_COS:      prdata = fprm_pkg::DATA_W'(unsigned'(cos_q));
			fprm_pkg::REG_SIN:      prdata = fprm_pkg::DATA_W'(unsigned'(sin_q));
			fprm_pkg::REG_TAN_HALF: prdata = fprm_pkg::DATA_W'(unsigned'(tan_q));
			fprm_pkg::REG_SRC_CX:   prdata = fprm_pkg::DATA_W'(unsigned'(scx_q));
			fprm_pkg::REG_SRC_CY:   prdata = fprm_pkg::DATA_W'(unsigned'(scy_q));
			fprm_pkg::REG_DST_CX:   prdata = fprm_pkg::DATA_W'(unsigned'(dcx_q));
			fprm_pkg::REG_DST_CY:   prdata = fprm_pkg::DATA_W'(unsigned'(dcy_q));
			default:                prdata = '0;
		endcase
	end

	// ---------------------------------------------------------- stage control
	// A stage loads when it is empty or the stage after it loads too.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	assign en_s8 = ~valid_s8 | out_ready;
	assign en_s7 = ~valid_s7 | en_s8;
	assign en_s6 = ~valid_s6 | en_s7;
	assign en_s5 = ~valid_s5 | en_s6;
	assign en_s4 = ~valid_s4 | en_s5;
	assign en_s3 = ~valid_s3 | en_s4;
	assign en_s2 = ~valid_s2 | en_s3;
	assign en_s1 = ~valid_s1 | en_s2;

	assign in_ready  = en_s1;
	assign out_valid = valid_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
			if (en_s7) valid_s7 <= valid_s6;
			if (en_s8) valid_s8 <= valid_s7;
		end
	end

	// --------------------------------------------------------------- datapath
	fprm_pkg::pix_info_t info_s1, info_s2, info_s3, info_s4, info_s5, info_s6, info_s7;

	logic signed [fprm_pkg::OFF_W-1:0] tx_s1, ty_s1, tx_s2, ty_s2, ty_s3, ty_s4;

	// stage 2 products
	logic signed [fprm_pkg::COEF_W+fprm_pkg::OFF_W-1:0] pcx_s2, psy_s2, psx_s2, pcy_s2;
	logic signed [fprm_pkg::TAN_W+fprm_pkg::OFF_W-1:0]  pty_s2;

	logic signed [fprm_pkg::ROT_W-1:0] dx_s3, dy_s3, dx_s4, dy_s4, dx_s5, dy_s5;
	logic signed [fprm_pkg::ROT_W-1:0] dx_s6, dy_s6, dx_s7, dy_s7;
	logic signed [fprm_pkg::A_W-1:0]   a_s3, a_s4, a_s5, a_s6;

	logic signed [fprm_pkg::A_W+fprm_pkg::COEF_W-1:0] pas_s4;
	logic signed [fprm_pkg::B_W+fprm_pkg::TAN_W-1:0]  pbt_s6;

	// combinational stage results
	logic signed [fprm_pkg::RND_W-1:0]  sum_x, sum_y, shear_a, shear_b, shear_c;
	logic signed [fprm_pkg::RND_W-1:0]  rnd_x, rnd_y, rnd_a, rnd_b, rnd_c;
	logic signed [fprm_pkg::B_W-1:0]    b_s5;
	logic signed [fprm_pkg::WIDE_W-1:0] wx, wy, rx, ry;

	always_comb begin
		// stage 3: direct sums, or first shear
		sum_x   = fprm_pkg::RND_W'(pcx_s2) - fprm_pkg::RND_W'(psy_s2);
		sum_y   = fprm_pkg::RND_W'(psx_s2) + fprm_pkg::RND_W'(pcy_s2);
		shear_a = (fprm_pkg::RND_W'(tx_s2) <<< fprm_pkg::Q_BITS) - fprm_pkg::RND_W'(pty_s2);
		rnd_x   = fprm_pkg::q_round(sum_x, 1'b1);
		rnd_y   = fprm_pkg::q_round(sum_y, 1'b0);
		rnd_a   = fprm_pkg::q_round(shear_a, 1'b1);
		// stage 5: second shear
		shear_b = fprm_pkg::RND_W'(pas_s4) + (fprm_pkg::RND_W'(ty_s4) <<< fprm_pkg::Q_BITS);
		rnd_b   = fprm_pkg::q_round(shear_b, 1'b1);
		// stage 7: third shear
		shear_c = (fprm_pkg::RND_W'(a_s6) <<< fprm_pkg::Q_BITS) - fprm_pkg::RND_W'(pbt_s6);
		rnd_c   = fprm_pkg::q_round(shear_c, 1'b1);
		// stage 8: add the destination center
		wx = fprm_pkg::WIDE_W'(dcx_q) + fprm_pkg::WIDE_W'(dx_s7);
		wy = fprm_pkg::WIDE_W'(dcy_q) + fprm_pkg::WIDE_W'(dy_s7);
		rx = fprm_pkg::WIDE_W'(info_s7.sx);
		ry = fprm_pkg::WIDE_W'(info_s7.sy);
	end

	assign b_s5 = dy_s5[fprm_pkg::B_W-1:0];

	always_ff @(posedge clk) begin
		// stage 1: center on the figure
		if (en_s1) begin
			info_s1.sx     <= src_x;
			info_s1.sy     <= src_y;
			info_s1.filled <= filled;
			info_s1.mode   <= mode_q;
			tx_s1 <= fprm_pkg::OFF_W'(src_x) - fprm_pkg::OFF_W'(scx_q);
			ty_s1 <= fprm_pkg::OFF_W'(src_y) - fprm_pkg::OFF_W'(scy_q);
		end
		// stage 2: rotation products, or ty*tan
		if (en_s2) begin
			info_s2 <= info_s1;
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			pcx_s2  <= cos_q * tx_s1;
			psy_s2  <= sin_q * ty_s1;
			psx_s2  <= sin_q * tx_s1;
			pcy_s2  <= cos_q * ty_s1;
			pty_s2  <= tan_q * ty_s1;
		end
		if (en_s3) begin
			info_s3 <= info_s2;
			ty_s3   <= ty_s2;
			dx_s3   <= rnd_x[fprm_pkg::ROT_W-1:0];
			dy_s3   <= rnd_y[fprm_pkg::ROT_W-1:0];
			a_s3    <= rnd_a[fprm_pkg::A_W-1:0];
		end
		// stage 4: a*sin
		if (en_s4) begin
			info_s4 <= info_s3;
			ty_s4   <= ty_s3;
			dx_s4   <= dx_s3;
			dy_s4   <= dy_s3;
			a_s4    <= a_s3;
			pas_s4  <= a_s3 * sin_q;
		end
		// stage 5: b replaces dy in shear mode
		if (en_s5) begin
			info_s5 <= info_s4;
			dx_s5   <= dx_s4;
			dy_s5   <= (info_s4.mode == fprm_pkg::MODE_SHEAR) ?
			           rnd_b[fprm_pkg::ROT_W-1:0] : dy_s4;
			a_s5    <= a_s4;
		end
		// stage 6: b*tan
		if (en_s6) begin
			info_s6 <= info_s5;
			dx_s6   <= dx_s5;
			dy_s6   <= dy_s5;
			a_s6    <= a_s5;
			pbt_s6  <= b_s5 * tan_q;
		end
		// stage 7: c replaces dx in shear mode
		if (en_s7) begin
			info_s7 <= info_s6;
			dx_s7   <= (info_s6.mode == fprm_pkg::MODE_SHEAR) ?
			           rnd_c[fprm_pkg::ROT_W-1:0] : dx_s6;
			dy_s7   <= dy_s6;
		end
		// stage 8: output register
		if (en_s8) begin
			read_x       <= info_s7.sx;
			read_y       <= info_s7.sy;
			write_x      <= fprm_pkg::sat_out(wx);
			write_y      <= fprm_pkg::sat_out(wy);
			write_enable <= info_s7.filled & fprm_pkg::in_image(rx, ry)
			                & fprm_pkg::in_image(wx, wy);
		end
	end

endmodule

[hw/rtl/fprm_checker.sv]
// Port-level assertions for the pixel rotation mapper, bound to its top level.
module fprm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [fprm_pkg::COORD_W-1:0]  read_x,
	input logic signed [fprm_pkg::COORD_W-1:0]  read_y,
	input logic signed [fprm_pkg::OUT_W-1:0]    write_x,
	input logic signed [fprm_pkg::OUT_W-1:0]    write_y,
	input logic                                 write_enable
);

	// Reset empties the pipeline.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result shown during reset");

	// With no result pending the pipeline cannot be full.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A write is only enabled for points inside the image.
	a_write_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |->
		write_x >= 0 && write_x < fprm_pkg::IMAGE_WIDTH &&
		write_y >= 0 && write_y < fprm_pkg::IMAGE_HEIGHT &&
		read_x >= 0 && read_x < fprm_pkg::IMAGE_WIDTH &&
		read_y >= 0 && read_y < fprm_pkg::IMAGE_HEIGHT)
		else $error("write enabled outside the image");

	// Hold a stalled result.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(write_x) && $stable(write_y) &&
		$stable(read_x) && $stable(read_y) && $stable(write_enable))
		else $error("stalled result changed");

endmodule

bind figure_pixel_rotation_mapper fprm_checker u_fprm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_x       (read_x),
	.read_y       (read_y),
	.write_x      (write_x),
	.write_y      (write_y),
	.write_enable (write_enable)
);

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the figure pixel rotation mapper: pixels checked against a mapping model.
module testbench;

	localparam int RX_HOLD   = 300;  // cycles of the one long receiver hold-off
	localparam int IDLE_PCT  = 23;   // chance in percent that a side idles in a cycle
	localparam int SETTLE    = 12;   // cycles past the last result, above the pipeline depth

	// One pixel as offered on the input channel.
	typedef struct {
		logic signed [fprm_pkg::COORD_W-1:0] x;
		logic signed [fprm_pkg::COORD_W-1:0] y;
		logic                                fl;
	} pixel_t;

	// One mapped pixel as it should leave the output channel.
	typedef struct {
		logic signed [fprm_pkg::COORD_W-1:0] rd_x;
		logic signed [fprm_pkg::COORD_W-1:0] rd_y;
		logic signed [fprm_pkg::OUT_W-1:0]   wr_x;
		logic signed [fprm_pkg::OUT_W-1:0]   wr_y;
		logic                                wr_en;
	} mapping_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                psel = 1'b0;
	logic                                penable = 1'b0;
	logic                                pwrite = 1'b0;
	logic [fprm_pkg::ADDR_W-1:0]         paddr = '0;
	logic [fprm_pkg::DATA_W-1:0]         pwdata = '0;
	logic [fprm_pkg::DATA_W-1:0]         prdata;
	logic                                pready;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic signed [fprm_pkg::COORD_W-1:0] src_x = '0;
	logic signed [fprm_pkg::COORD_W-1:0] src_y = '0;
	logic                                filled = 1'b0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [fprm_pkg::COORD_W-1:0] read_x;
	logic signed [fprm_pkg::COORD_W-1:0] read_y;
	logic signed [fprm_pkg::OUT_W-1:0]   write_x;
	logic signed [fprm_pkg::OUT_W-1:0]   write_y;
	logic                                write_enable;

	// Shadow copy of the rotation registers, updated at each register write.
	logic                                rot_mode = fprm_pkg::MODE_DIRECT;
	logic signed [fprm_pkg::COEF_W-1:0]  rot_cos = 16'sd16384;
	logic signed [fprm_pkg::COEF_W-1:0]  rot_sin = '0;
	logic signed [fprm_pkg::TAN_W-1:0]   rot_tan = '0;
	logic signed [fprm_pkg::COORD_W-1:0] rot_src_cx = '0;
	logic signed [fprm_pkg::COORD_W-1:0] rot_src_cy = '0;
	logic signed [fprm_pkg::COORD_W-1:0] rot_dst_cx = '0;
	logic signed [fprm_pkg::COORD_W-1:0] rot_dst_cy = '0;

	pixel_t   pending_pixels[$];  // pixels waiting to be offered
	mapping_t expected_maps[$];   // mappings of accepted pixels, oldest first
	pixel_t   offer;
	pixel_t   taken;
	mapping_t want;

	int errors = 0;
	int hold_count = 0;
	bit no_idle = 1'b0;  // both sides stay busy while set
	bit hold_rx = 1'b0;  // start the long receiver hold-off

	figure_pixel_rotation_mapper dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Q14 to integer on the magnitude, either half away from zero or toward zero.
	function automatic longint q14_to_int(longint v, bit away);
		longint mag;
		longint half;
		half = away ? (longint'(1) << (fprm_pkg::Q_BITS - 1)) : longint'(0);
		mag = (v < 0) ? -v : v;
		mag = (mag + half) >>> fprm_pkg::Q_BITS;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint clamp_out(longint v);
		longint hi;
		hi = (longint'(1) << (fprm_pkg::OUT_W - 1)) - 1;
		if (v > hi) begin
			return hi;
		end else if (v < -hi - 1) begin
			return -hi - 1;
		end
		return v;
	endfunction

	function automatic bit on_image(longint x, longint y);
		return x >= 0 && x < fprm_pkg::IMAGE_WIDTH && y >= 0 && y < fprm_pkg::IMAGE_HEIGHT;
	endfunction

	// Map one pixel with the current register settings.
	function automatic mapping_t map_pixel(pixel_t p);
		mapping_t m;
		longint one, tx, ty, dx, dy, a, b, wx, wy;
		one = longint'(1) << fprm_pkg::Q_BITS;
		tx = longint'(p.x) - longint'(rot_src_cx);
		ty = longint'(p.y) - longint'(rot_src_cy);
		if (rot_mode == fprm_pkg::MODE_DIRECT) begin
			// x rounds half away from zero, y truncates toward zero
			dx = q14_to_int(longint'(rot_cos) * tx - longint'(rot_sin) * ty, 1'b1);
			dy = q14_to_int(longint'(rot_sin) * tx + longint'(rot_cos) * ty, 1'b0);
		end else begin
			// three shears, each rounded to an integer
			a = q14_to_int(tx * one - ty * longint'(rot_tan), 1'b1);
			b = q14_to_int(a * longint'(rot_sin) + ty * one, 1'b1);
			dx = q14_to_int(a * one - b * longint'(rot_tan), 1'b1);
			dy = b;
		end
		wx = longint'(rot_dst_cx) + dx;
		wy = longint'(rot_dst_cy) + dy;
		m.rd_x = p.x;
		m.rd_y = p.y;
		m.wr_x = fprm_pkg::OUT_W'(clamp_out(wx));
		m.wr_y = fprm_pkg::OUT_W'(clamp_out(wy));
		// judge the write on the unsaturated destination
		m.wr_en = p.fl && on_image(p.x, p.y) && on_image(wx, wy);
		return m;
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Write one register: setup cycle, then access cycle; the write lands at the end of the access cycle.
	task automatic write_reg(fprm_pkg::reg_idx_t idx, int val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= fprm_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= fprm_pkg::DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			fprm_pkg::REG_MODE:     rot_mode   = val[0];
			fprm_pkg::REG_COS:      rot_cos    = fprm_pkg::COEF_W'(val);
			fprm_pkg::REG_SIN:      rot_sin    = fprm_pkg::COEF_W'(val);
			fprm_pkg::REG_TAN_HALF: rot_tan    = fprm_pkg::TAN_W'(val);
			fprm_pkg::REG_SRC_CX:   rot_src_cx = fprm_pkg::COORD_W'(val);
			fprm_pkg::REG_SRC_CY:   rot_src_cy = fprm_pkg::COORD_W'(val);
			fprm_pkg::REG_DST_CX:   rot_dst_cx = fprm_pkg::COORD_W'(val);
			fprm_pkg::REG_DST_CY:   rot_dst_cy = fprm_pkg::COORD_W'(val);
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic md, int co, int si, int ta,
	                             int scx, int scy, int dcx, int dcy);
		write_reg(fprm_pkg::REG_MODE, int'(md));
		write_reg(fprm_pkg::REG_COS, co);
		write_reg(fprm_pkg::REG_SIN, si);
		write_reg(fprm_pkg::REG_TAN_HALF, ta);
		write_reg(fprm_pkg::REG_SRC_CX, scx);
		write_reg(fprm_pkg::REG_SRC_CY, scy);
		write_reg(fprm_pkg::REG_DST_CX, dcx);
		write_reg(fprm_pkg::REG_DST_CY, dcy);
		@(negedge clk);
	endtask

	task automatic queue_pixel(int x, int y, bit fl);
		pixel_t p;
		p.x = fprm_pkg::COORD_W'(x);
		p.y = fprm_pkg::COORD_W'(y);
		p.fl = fl;
		pending_pixels.push_back(p);
	endtask

	// Most pixels fall around the figure center so that many land on the image;
	// the rest span the whole coordinate range.
	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 6) begin
				queue_pixel(int'(rot_src_cx) + int'($urandom_range(0, 1200)) - 600,
				            int'(rot_src_cy) + int'($urandom_range(0, 1200)) - 600,
				            $urandom_range(0, 3) != 0);
			end else begin
				queue_pixel(int'($urandom()), int'($urandom()), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Hold until every queued pixel has been transferred and mapped, then settle.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_maps.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_phase(logic md, int co, int si, int ta,
	                         int scx, int scy, int dcx, int dcy, int n);
		apply_setting(md, co, si, ta, scx, scy, dcx, dcy);
		queue_random(n);
		wait_idle();
	endtask

	// Sender: record the mapping of each transfer, then offer the next pixel or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				taken.x = src_x;
				taken.y = src_y;
				taken.fl = filled;
				expected_maps.push_back(map_pixel(taken));
			end
			// hold the payload until it is taken
			if (!in_valid || in_ready) begin
				if (pending_pixels.size() != 0 &&
				    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
					offer = pending_pixels.pop_front();
					in_valid <= 1'b1;
					src_x    <= offer.x;
					src_y    <= offer.y;
					filled   <= offer.fl;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: one long hold-off on request, random stalls otherwise.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_rx && hold_count < RX_HOLD) begin
			out_ready  <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Monitor: compare each result transfer with the oldest expected mapping.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_maps.size() == 0) begin
				$display("%0t: result with none expected, read_x %0d read_y %0d write_x %0d",
				         $time, read_x, read_y, write_x);
				errors++;
			end else begin
				want = expected_maps.pop_front();
				check_field("read_x", want.rd_x, read_x);
				check_field("read_y", want.rd_y, read_y);
				check_field("write_x", want.wr_x, write_x);
				check_field("write_y", want.wr_y, write_y);
				check_field("write_enable", want.wr_en, write_enable);
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings map each pixel onto itself: probe the image borders,
		// the coordinate extremes and unfilled pixels.
		queue_pixel(0, 0, 1'b1);
		queue_pixel(1023, 1023, 1'b1);
		queue_pixel(1024, 0, 1'b1);
		queue_pixel(0, 1024, 1'b1);
		queue_pixel(-1, 0, 1'b1);
		queue_pixel(0, -1, 1'b1);
		queue_pixel(512, 512, 1'b0);
		queue_pixel(-4096, -4096, 1'b1);
		queue_pixel(4095, 4095, 1'b1);
		queue_pixel(4095, -4096, 1'b0);
		queue_pixel(-4096, 4095, 1'b1);
		queue_pixel(1023, 0, 1'b1);
		queue_pixel(0, 1023, 1'b1);
		queue_random(60);
		wait_idle();

		// direct rotations: identity, 90 and 180 degrees, half-step coefficients
		run_phase(fprm_pkg::MODE_DIRECT, 16384, 0, 0, 512, 512, 600, 400, 100);
		run_phase(fprm_pkg::MODE_DIRECT, 0, 16384, 0, 300, 700, 500, 500, 100);
		run_phase(fprm_pkg::MODE_DIRECT, -16384, 0, 0, 512, 512, 511, 511, 80);
		run_phase(fprm_pkg::MODE_DIRECT, 8192, -8192, 0, 401, 623, 512, 512, 100);

		// Shear at 30 degrees: keep the sender busy while the receiver holds off,
		// so the pipeline fills and stalls its input.
		apply_setting(fprm_pkg::MODE_SHEAR, 14189, 8192, 4390, 500, 500, 520, 480);
		no_idle = 1'b1;
		hold_rx = 1'b1;
		queue_random(300);
		wait_idle();
		no_idle = 1'b0;

		run_phase(fprm_pkg::MODE_SHEAR, 0, int'($urandom_range(0, 32768)) - 16384,
		          int'($urandom_range(0, 131072)) - 65536, 512, 512, 512, 512, 120);

		// shear with the extreme tangent and centers: destinations saturate
		apply_setting(fprm_pkg::MODE_SHEAR, -16384, -16384, -4194304, -4096, -4096,
		              4095, 4095);
		queue_pixel(4095, 4095, 1'b1);
		queue_pixel(-4096, -4096, 1'b1);
		queue_pixel(0, 0, 1'b1);
		queue_random(40);
		wait_idle();
		run_phase(fprm_pkg::MODE_SHEAR, 16384, 16384, 4194303, 4095, 4095, -4096, -4096, 40);

		run_phase(fprm_pkg::MODE_DIRECT, -16384, 16384, 0, -4096, -4096, 4095, 4095, 60);
		// coefficients beyond one are used as written
		run_phase(fprm_pkg::MODE_DIRECT, 32767, -32768, 0, 512, 512, 512, 512, 40);

		// settings drawn at random
		for (int k = 0; k < 2; k++) begin
			run_phase(1'($urandom_range(0, 1)), int'($urandom_range(0, 32768)) - 16384,
			          int'($urandom_range(0, 32768)) - 16384,
			          int'($urandom_range(0, 65536)) - 32768,
			          int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
			          int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)), 30);
		end

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Drop the run if it hangs.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
